// File: design/scc_pkg.sv
`timescale 1ns / 1ps

package scc_pkg;

  // Field widths fixed by the interface
  localparam int COORD_W   = 16;
  localparam int CFG_W     = 10;
  localparam int REG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_CENTRE_X    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CENTRE_Y    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RING_RADIUS = 2'd2;

  // Configuration reset values
  localparam logic [CFG_W-1:0] CENTRE_X_RST    = 10'd160;
  localparam logic [CFG_W-1:0] CENTRE_Y_RST    = 10'd120;
  localparam logic [CFG_W-1:0] RING_RADIUS_RST = 10'd100;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // latch the segment, reset the trial counter
    logic issue;       // launch the next trial point into the pipe
    logic flush;       // drop trials still in flight
    logic take_hit;    // capture the trial leaving the pipe as the result
    logic take_start;  // capture the start point as the result
    logic out_load;    // move the result into the output register
  } scc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic issue_last;  // trial counter sits on the trial nearest the start
    logic res_valid;   // a trial leaves the pipe this cycle
    logic res_inside;  // that trial lies inside the circle
    logic res_last;    // that trial is the one nearest the start
  } scc_stat_t;

endpackage

// File: design/segment_clip_to_circle.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  start_x, start_y, end_x, end_y (16b signed)
// out_      output     out_valid/out_stall  clipped_x, clipped_y (16b signed), was_clipped
// cfg_      input      cfg_valid/cfg_ready  cfg_index (2b), cfg_data (10b)
//
// One segment at a time. The end point and up to STEP_COUNT-1 trial points stream
// through a four-stage compute pipe, one per cycle. The output register holds a result
// under out_stall; the next segment is taken once the previous result has entered that
// register. Synchronous active-low reset restores centre (160,120) and radius 100.
`timescale 1ns / 1ps

module segment_clip_to_circle #(
  parameter int STEP_COUNT = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  input  logic signed [15:0] in_end_x,
  input  logic signed [15:0] in_end_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_clipped_x,
  output logic signed [15:0] out_clipped_y,
  output logic               out_was_clipped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data
);
  import scc_pkg::*;

  logic [CFG_W-1:0] centre_x_r, centre_y_r, ring_radius_r;
  scc_cmd_t         cmd;
  scc_stat_t        stat;

  // Configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_x_r    <= CENTRE_X_RST;
      centre_y_r    <= CENTRE_Y_RST;
      ring_radius_r <= RING_RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTRE_X:    centre_x_r    <= cfg_data;
        REG_CENTRE_Y:    centre_y_r    <= cfg_data;
        REG_RING_RADIUS: ring_radius_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  scc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  scc_datapath #(
    .STEP_COUNT (STEP_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .start_x     (in_start_x),
    .start_y     (in_start_y),
    .end_x       (in_end_x),
    .end_y       (in_end_y),
    .centre_x    (centre_x_r),
    .centre_y    (centre_y_r),
    .ring_radius (ring_radius_r),
    .clipped_x   (out_clipped_x),
    .clipped_y   (out_clipped_y),
    .was_clipped (out_was_clipped)
  );

endmodule

// File: design/scc_ctrl.sv
`timescale 1ns / 1ps

module scc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_stall,
  output logic              out_valid,
  input  scc_pkg::scc_stat_t stat,
  output scc_pkg::scc_cmd_t  cmd
);
  import scc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       issuing_r, issuing_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       hit;

  assign hit = stat.res_valid && stat.res_inside;

  // Sequencer: load, stream trials, pick the first hit, hand off
  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    issuing_nxt = issuing_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          issuing_nxt = 1'b1;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (hit) begin
          cmd.take_hit = 1'b1;
          cmd.flush    = 1'b1;
          issuing_nxt  = 1'b0;
          state_nxt    = ST_DONE;
        end else begin
          cmd.issue = issuing_r;
          if (issuing_r && stat.issue_last) begin
            issuing_nxt = 1'b0;
          end
          // no trial hit: fall back to the start point
          if (stat.res_valid && stat.res_last) begin
            cmd.take_start = 1'b1;
            state_nxt      = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt   = ST_IDLE;
        issuing_nxt = 1'b0;
      end
    endcase
  end

  // Output register occupancy
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issuing_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issuing_r   <= issuing_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: design/scc_datapath.sv
`timescale 1ns / 1ps

module scc_datapath #(
  parameter int STEP_COUNT = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  scc_pkg::scc_cmd_t  cmd,
  output scc_pkg::scc_stat_t stat,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  input  logic [9:0]         centre_x,
  input  logic [9:0]         centre_y,
  input  logic [9:0]         ring_radius,
  output logic signed [15:0] clipped_x,
  output logic signed [15:0] clipped_y,
  output logic               was_clipped
);
  import scc_pkg::*;

  // Trial numerator n runs STEP_COUNT down to 1; the trial is start + round(d*n/S)
  localparam int KW     = $clog2(STEP_COUNT + 1);
  localparam int PW     = COORD_W + KW;           // |d| * n
  localparam int NUM_W  = PW + 1;                 // 2*|d|*n + S
  localparam int DIV_D  = 2 * STEP_COUNT;
  localparam int DIV_L  = $clog2(DIV_D);
  localparam int DIV_SH = NUM_W + DIV_L;
  localparam int MAG_W  = NUM_W + 2;
  localparam int PRD_W  = NUM_W + MAG_W;
  // ceil(2^DIV_SH / DIV_D): exact floor division for every NUM_W-bit numerator
  localparam longint MAGIC_L = ((longint'(1) << DIV_SH) + DIV_D - 1) / DIV_D;
  localparam logic [MAG_W-1:0] MAGIC    = MAG_W'(MAGIC_L);
  localparam logic [KW-1:0]    NUM_TOP  = KW'(STEP_COUNT);
  localparam logic [KW-1:0]    NUM_ONE  = KW'(1);
  localparam logic [NUM_W-1:0] NUM_BIAS = NUM_W'(STEP_COUNT);

  // Segment registers
  logic signed [15:0] sx_r, sy_r;
  logic [15:0]        adx_r, ady_r;
  logic               negx_r, negy_r;
  logic [19:0]        r2_r;
  logic [KW-1:0]      num_r;

  logic signed [16:0] dx_w, dy_w;
  assign dx_w = {end_x[15], end_x} - {start_x[15], start_x};
  assign dy_w = {end_y[15], end_y} - {start_y[15], start_y};

  // Load segment and step the trial counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r   <= start_x;
      sy_r   <= start_y;
      negx_r <= dx_w[16];
      negy_r <= dy_w[16];
      adx_r  <= dx_w[16] ? 16'(-dx_w) : dx_w[15:0];
      ady_r  <= dy_w[16] ? 16'(-dy_w) : dy_w[15:0];
      r2_r   <= 20'(ring_radius) * 20'(ring_radius);
      num_r  <= NUM_TOP;
    end else if (cmd.issue) begin
      num_r <= num_r - NUM_ONE;
    end
  end

  // Pipe valids
  logic v1_r, v2_r, v3_r, v4_r;
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.flush) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Stage 1: |d| * n
  logic [PW-1:0] mx1_r, my1_r;
  logic          f1_r, l1_r;
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      mx1_r <= PW'(adx_r) * PW'(num_r);
      my1_r <= PW'(ady_r) * PW'(num_r);
      f1_r  <= (num_r == NUM_TOP);
      l1_r  <= (num_r == NUM_ONE);
    end
  end

  // Stage 2: (2|d|n + S) times reciprocal of 2S
  logic [NUM_W-1:0] nx_w, ny_w;
  logic [PRD_W-1:0] qx2_r, qy2_r;
  logic             f2_r, l2_r;
  assign nx_w = {mx1_r, 1'b0} + NUM_BIAS;
  assign ny_w = {my1_r, 1'b0} + NUM_BIAS;
  always_ff @(posedge clk) begin
    qx2_r <= PRD_W'(nx_w) * PRD_W'(MAGIC);
    qy2_r <= PRD_W'(ny_w) * PRD_W'(MAGIC);
    f2_r  <= f1_r;
    l2_r  <= l1_r;
  end

  // Stage 3: signed offset onto start, then distance to centre
  logic [15:0]        qx_w, qy_w;
  logic [17:0]        px_w, py_w;
  logic signed [15:0] px3_r, py3_r;
  logic signed [16:0] ox3_r, oy3_r;
  logic               f3_r, l3_r;
  assign qx_w = qx2_r[DIV_SH +: COORD_W];
  assign qy_w = qy2_r[DIV_SH +: COORD_W];
  assign px_w = {{2{sx_r[15]}}, sx_r} + (negx_r ? 18'(-{2'b00, qx_w}) : {2'b00, qx_w});
  assign py_w = {{2{sy_r[15]}}, sy_r} + (negy_r ? 18'(-{2'b00, qy_w}) : {2'b00, qy_w});
  always_ff @(posedge clk) begin
    px3_r <= px_w[15:0];
    py3_r <= py_w[15:0];
    ox3_r <= $signed({px_w[15], px_w[15:0]} - {7'b0, centre_x});
    oy3_r <= $signed({py_w[15], py_w[15:0]} - {7'b0, centre_y});
    f3_r  <= f2_r;
    l3_r  <= l2_r;
  end

  // Stage 4: squares
  logic signed [33:0] sqx4_r, sqy4_r;
  logic signed [15:0] px4_r, py4_r;
  logic               f4_r, l4_r;
  always_ff @(posedge clk) begin
    sqx4_r <= ox3_r * ox3_r;
    sqy4_r <= oy3_r * oy3_r;
    px4_r  <= px3_r;
    py4_r  <= py3_r;
    f4_r   <= f3_r;
    l4_r   <= l3_r;
  end

  // Inside test on the trial leaving the pipe
  logic [34:0] dist2_w;
  assign dist2_w = {1'b0, $unsigned(sqx4_r)} + {1'b0, $unsigned(sqy4_r)};

  always_comb begin
    stat            = '0;
    stat.issue_last = (num_r == NUM_ONE);
    stat.res_valid  = v4_r;
    stat.res_inside = (dist2_w <= {15'b0, r2_r});
    stat.res_last   = l4_r;
  end

  // Result capture and output register
  logic signed [15:0] res_x_r, res_y_r, out_x_r, out_y_r;
  logic               res_clip_r, out_clip_r;
  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      res_x_r    <= px4_r;
      res_y_r    <= py4_r;
      res_clip_r <= !f4_r;   // the full-length trial is the end point itself
    end else if (cmd.take_start) begin
      res_x_r    <= sx_r;
      res_y_r    <= sy_r;
      res_clip_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_x_r    <= res_x_r;
      out_y_r    <= res_y_r;
      out_clip_r <= res_clip_r;
    end
  end

  assign clipped_x   = out_x_r;
  assign clipped_y   = out_y_r;
  assign was_clipped = out_clip_r;

endmodule

// File: design/scc_checker.sv
`timescale 1ns / 1ps

module scc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_clipped_x,
  input logic [15:0] out_clipped_y,
  input logic        out_was_clipped
);

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_clipped_x) &&
      $stable(out_clipped_y) && $stable(out_was_clipped)))
    else $error("result changed while stalled");

  // One segment in flight: input closes right after a transaction
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second segment taken while one is in flight");

  // A result cannot be produced in the cycle right after a transaction
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind segment_clip_to_circle scc_checker u_scc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_clipped_x   (out_clipped_x),
  .out_clipped_y   (out_clipped_y),
  .out_was_clipped (out_was_clipped)
);
